// File: src/assert_macros.svh
// Assertion macros shared by the RTL of the activation square accumulator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/asa_pkg.sv
// Types, constants and codes of the activation square accumulator.
`timescale 1ns / 1ps
package asa_pkg;

  localparam int MAX_COLUMNS = 1024;
  localparam int MAX_EXPERTS = 8;
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int EXP_W       = $clog2(MAX_EXPERTS);
  localparam int IDX_W       = COL_W + EXP_W;
  localparam int ENTRIES     = MAX_COLUMNS * MAX_EXPERTS;

  localparam int SUM_W    = 48;
  localparam int CNT_W    = 32;
  localparam int CALL_W   = 16;
  localparam int SQ_W     = 32;
  localparam int PROD_W   = SUM_W + CALL_W;
  localparam int CFG_W    = 11;
  localparam int CFGCOL_W = 11;
  localparam int CFGEXP_W = 4;

  typedef enum logic [1:0] {
    CMD_ACC  = 2'd0,
    CMD_END  = 2'd1,
    CMD_READ = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    STATUS_OK       = 3'd0,
    STATUS_OVERFLOW = 3'd1,
    STATUS_RANGE    = 3'd2,
    STATUS_NODATA   = 3'd3,
    STATUS_HALTED   = 3'd4
  } status_t;

  typedef enum logic {
    CFG_COLUMNS = 1'b0,
    CFG_EXPERTS = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_RUN,
    ST_DIVIDE,
    ST_DONE
  } asa_state_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// File: src/asa_ram.sv
// Simple dual-port synchronous RAM with registered read.
`timescale 1ns / 1ps
module asa_ram #(
  parameter int DEPTH = 8192,
  parameter int WIDTH = 80
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/asa_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module asa_div import asa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PROD_W-1:0] dividend,
  input  logic [CNT_W-1:0]  divisor,
  output logic              done,
  output logic [PROD_W-1:0] quotient
);

  localparam int STEP_W = $clog2(PROD_W);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [CNT_W-1:0]  rem_r;
  logic [PROD_W-1:0] quo_r;
  logic [CNT_W-1:0]  dvs_r;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    diff;
  logic              take;

  always_comb begin
    rem_sh = {rem_r, quo_r[PROD_W-1]};
    diff   = rem_sh - {1'b0, dvs_r};
    take   = (rem_sh >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (step_r == '0);
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (step_r == '0)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      quo_r  <= dividend;
      dvs_r  <= divisor;
      step_r <= '1;
    end else if (busy_r) begin
      rem_r  <= take ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      quo_r  <= {quo_r[PROD_W-2:0], take};
      step_r <= step_r - 1'b1;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: src/activation_square_accumulator.sv
// Activation square accumulator: per-(expert, column) sums of squares and counts.
//
// Input channel (in_valid/in_ready) takes one command beat: cmd 0 adds
// sample^2 (Q8.8 in, Q32.16 sum) into entry {expert, column}, cmd 1 counts
// one finished call, cmd 2 reads sum*calls/count. Every beat gives exactly
// one result beat on out_valid/out_ready (status, scaled_mean, sample_count).
// Configuration (cfg_we, cfg_index, cfg_wdata) sets columns and experts in use;
// write it only while the block is idle.
// Accumulate, end-of-call, no-op, range-error and no-data beats run through a
// read/modify/write pipeline around one 8192 x 80 RAM: one beat per cycle while
// the output register is free; each result passes the stage register and then
// the output register. A read following a write to the same entry is served by
// a forward register. A read with data holds the pipeline for the 64-step divider.
// After reset the RAM is cleared one entry per cycle, with in_ready low.
// When out_ready is low the result waits in the output register; the next
// beat may enter and then waits behind it.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module activation_square_accumulator import asa_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [CFG_W-1:0]    cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_cmd,
  input  logic [EXP_W-1:0]    in_expert,
  input  logic [COL_W-1:0]    in_column,
  input  logic signed [15:0]  in_sample,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          out_status,
  output logic [SUM_W-1:0]    out_scaled_mean,
  output logic [CNT_W-1:0]    out_sample_count
);

  asa_state_t state_r, state_nxt;

  logic [CFGCOL_W-1:0] columns_in_use_r;
  logic [CFGEXP_W-1:0] experts_in_use_r;
  logic [IDX_W-1:0]    clr_cnt_r;
  logic                halted_r, halted_nxt;
  logic [CALL_W-1:0]   call_total_r, call_total_nxt;

  // pipeline stage
  logic             b_valid_r, b_valid_nxt;
  cmd_t             b_cmd_r;
  logic [IDX_W-1:0] b_idx_r;
  logic             b_range_r;
  logic [SQ_W-1:0]  b_sq_r;

  // forward of the last functional write
  logic             fwd_valid_r;
  logic [IDX_W-1:0] fwd_idx_r;
  entry_t           fwd_data_r;

  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, res_status;
  logic [SUM_W-1:0]    out_mean_r, res_mean;
  logic [CNT_W-1:0]    out_cnt_r, res_cnt;

  logic             accept, ofree, emit, acc_write;
  logic             in_range;
  logic [15:0]      mag;
  logic [SQ_W-1:0]  sq;
  entry_t           rd_entry, ram_rdata, acc_entry;
  logic [SUM_W:0]   sum_ext;
  logic             sum_ovf, cnt_ovf;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic             div_start, div_done;
  logic [PROD_W-1:0] div_dividend, div_quo;

  // request side
  assign accept   = in_valid && in_ready;
  assign in_range = ({1'b0, in_column} < columns_in_use_r)
                 && ({1'b0, in_expert} < experts_in_use_r);
  assign mag      = in_sample[15] ? (16'd0 - in_sample) : in_sample;
  assign sq       = mag * mag;

  asa_ram #(.DEPTH(ENTRIES), .WIDTH(ENTRY_W)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr ({in_expert, in_column}),
    .rdata (ram_rdata)
  );

  assign rd_entry = (fwd_valid_r && (fwd_idx_r == b_idx_r)) ? fwd_data_r : ram_rdata;

  always_comb begin
    sum_ext         = {1'b0, rd_entry.sum} + {{(SUM_W+1-SQ_W){1'b0}}, b_sq_r};
    sum_ovf         = sum_ext[SUM_W];
    cnt_ovf         = &rd_entry.count;
    acc_entry.sum   = sum_ovf ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
    acc_entry.count = cnt_ovf ? rd_entry.count : rd_entry.count + 1'b1;
  end

  assign div_dividend = {{CALL_W{1'b0}}, rd_entry.sum} * {{SUM_W{1'b0}}, call_total_r};

  asa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (rd_entry.count),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign ofree = !out_valid_r || out_ready;

  always_comb begin
    state_nxt      = state_r;
    in_ready       = 1'b0;
    emit           = 1'b0;
    acc_write      = 1'b0;
    div_start      = 1'b0;
    halted_nxt     = halted_r;
    call_total_nxt = call_total_r;
    res_status     = STATUS_OK;
    res_mean       = '0;
    res_cnt        = '0;
    b_valid_nxt    = b_valid_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (&clr_cnt_r) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (b_valid_r && (b_cmd_r == CMD_READ) && b_range_r && (rd_entry.count != '0)) begin
          div_start = 1'b1;
          state_nxt = ST_DIVIDE;
        end else begin
          emit     = b_valid_r && ofree;
          in_ready = !b_valid_r || ofree;
          unique case (b_cmd_r)
            CMD_ACC: begin
              if (halted_r) begin
                res_status = STATUS_HALTED;
              end else if (!b_range_r) begin
                res_status = STATUS_RANGE;
              end else begin
                acc_write = emit;
                if (sum_ovf || cnt_ovf) begin
                  res_status = STATUS_OVERFLOW;
                  if (emit) begin
                    halted_nxt = 1'b1;
                  end
                end
              end
            end
            CMD_END: begin
              if (emit && !(&call_total_r)) begin
                call_total_nxt = call_total_r + 1'b1;
              end
            end
            CMD_READ: begin
              res_status = b_range_r ? STATUS_NODATA : STATUS_RANGE;
            end
            default: begin
              res_status = STATUS_OK;
            end
          endcase
          b_valid_nxt = accept || (b_valid_r && !emit);
        end
      end
      ST_DIVIDE: begin
        if (div_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        res_cnt = rd_entry.count;
        if (div_quo[PROD_W-1:SUM_W] != '0) begin
          res_status = STATUS_OVERFLOW;
          res_mean   = {SUM_W{1'b1}};
        end else begin
          res_mean   = div_quo[SUM_W-1:0];
        end
        if (ofree) begin
          emit        = 1'b1;
          b_valid_nxt = 1'b0;
          state_nxt   = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  assign ram_we    = (state_r == ST_CLEAR) || acc_write;
  assign ram_waddr = (state_r == ST_CLEAR) ? clr_cnt_r : b_idx_r;
  assign ram_wdata = (state_r == ST_CLEAR) ? entry_t'('0) : acc_entry;

  assign out_valid_nxt = emit || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_CLEAR;
      clr_cnt_r        <= '0;
      columns_in_use_r <= CFGCOL_W'(MAX_COLUMNS);
      experts_in_use_r <= CFGEXP_W'(1);
      halted_r         <= 1'b0;
      call_total_r     <= '0;
      b_valid_r        <= 1'b0;
      fwd_valid_r      <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      halted_r     <= halted_nxt;
      call_total_r <= call_total_nxt;
      b_valid_r    <= b_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (acc_write) begin
        fwd_valid_r <= 1'b1;
      end
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_COLUMNS: columns_in_use_r <= cfg_wdata[CFGCOL_W-1:0];
          CFG_EXPERTS: experts_in_use_r <= cfg_wdata[CFGEXP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_cmd_r   <= cmd_t'(in_cmd);
      b_idx_r   <= {in_expert, in_column};
      b_range_r <= in_range;
      b_sq_r    <= sq;
    end
    if (acc_write) begin
      fwd_idx_r  <= b_idx_r;
      fwd_data_r <= acc_entry;
    end
    if (emit) begin
      out_status_r <= res_status;
      out_mean_r   <= res_mean;
      out_cnt_r    <= res_cnt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_scaled_mean  = out_mean_r;
  assign out_sample_count = out_cnt_r;

  `ASA_ASSERT_IMPL(a_clear_quiet, clk, rst_n, state_r == ST_CLEAR, !b_valid_r && !out_valid_r)
  `ASA_ASSERT_IMPL(a_div_start, clk, rst_n, div_start, b_valid_r && (b_cmd_r == CMD_READ))
  `ASA_ASSERT_NEXT(a_halt_sticky, clk, rst_n, halted_r, halted_r)
  `ASA_ASSERT_IMPL(a_no_write_halted, clk, rst_n, acc_write, !halted_r && b_range_r)

endmodule

// File: bench/tb_activation_square_accumulator.sv
// Self-checking testbench for the activation square accumulator.
`timescale 1ns / 1ps
module tb_activation_square_accumulator;
  import asa_pkg::*;

  localparam int STALL_LIMIT = 40000;
  localparam int Q_DEPTH     = 64;

  typedef struct packed {
    cmd_t             cmd;
    logic [EXP_W-1:0] expert;
    logic [COL_W-1:0] column;
    logic [15:0]      sample;
  } item_t;

  typedef struct packed {
    status_t          status;
    logic [SUM_W-1:0] mean;
    logic [CNT_W-1:0] count;
  } stats_t;

  logic                clk;
  logic                rst_n            = 1'b0;
  logic                cfg_we           = 1'b0;
  logic                cfg_index        = 1'b0;
  logic [CFG_W-1:0]    cfg_wdata        = '0;
  logic                in_valid         = 1'b0;
  logic                in_ready;
  logic [1:0]          in_cmd           = '0;
  logic [EXP_W-1:0]    in_expert        = '0;
  logic [COL_W-1:0]    in_column        = '0;
  logic signed [15:0]  in_sample        = '0;
  logic                out_valid;
  logic                out_ready        = 1'b0;
  logic [2:0]          out_status;
  logic [SUM_W-1:0]    out_scaled_mean;
  logic [CNT_W-1:0]    out_sample_count;

  activation_square_accumulator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_expert        (in_expert),
    .in_column        (in_column),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_scaled_mean  (out_scaled_mean),
    .out_sample_count (out_sample_count)
  );

  // predicted block state
  logic [SUM_W-1:0]    sum_store [ENTRIES];
  logic [CNT_W-1:0]    cnt_store [ENTRIES];
  logic [CALL_W-1:0]   calls;
  bit                  stopped;
  logic [CFGCOL_W-1:0] cols_cfg;
  logic [CFGEXP_W-1:0] exps_cfg;

  item_t       cmd_q [$];
  stats_t      resp_q [$];
  int unsigned issued     = 0;
  int unsigned checked    = 0;
  int unsigned mismatches = 0;
  bit          in_taken   = 1'b0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  bit          hold_go    = 1'b0;
  logic        rx_hold    = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic stats_t collect_stats(item_t b);
    stats_t            r;
    logic [IDX_W-1:0]  idx;
    logic [15:0]       mag;
    logic [SQ_W-1:0]   sq;
    logic [SUM_W:0]    total;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] quot;
    bit                hit;
    r.status = STATUS_OK;
    r.mean   = '0;
    r.count  = '0;
    hit = (b.column < cols_cfg) && (b.expert < exps_cfg);
    idx = {b.expert, b.column};
    case (b.cmd)
      CMD_ACC: begin
        if (stopped) begin
          r.status = STATUS_HALTED;
        end else if (!hit) begin
          r.status = STATUS_RANGE;
        end else begin
          mag   = b.sample[15] ? (~b.sample + 16'd1) : b.sample;
          sq    = mag * mag;
          total = sum_store[idx] + sq;
          if (total[SUM_W]) begin
            sum_store[idx] = '1;
            r.status = STATUS_OVERFLOW;
          end else begin
            sum_store[idx] = total[SUM_W-1:0];
          end
          if (&cnt_store[idx]) r.status = STATUS_OVERFLOW;
          else cnt_store[idx] = cnt_store[idx] + 1'b1;
          if (r.status == STATUS_OVERFLOW) stopped = 1'b1;
        end
      end
      CMD_END: begin
        if (!(&calls)) calls = calls + 1'b1;
      end
      CMD_READ: begin
        if (!hit) begin
          r.status = STATUS_RANGE;
        end else if (cnt_store[idx] == '0) begin
          r.status = STATUS_NODATA;
        end else begin
          prod = sum_store[idx] * calls;
          quot = prod / cnt_store[idx];
          if (quot[PROD_W-1:SUM_W] != '0) begin
            r.mean   = '1;
            r.status = STATUS_OVERFLOW;
          end else begin
            r.mean = quot[SUM_W-1:0];
          end
          r.count = cnt_store[idx];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t ns: %s mismatch, got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // sender and receiver, driven on the falling edge
  always @(negedge clk) begin : drive
    item_t beat;
    if (!in_valid || in_taken) begin
      if (cmd_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        beat = cmd_q.pop_front();
        in_valid  <= 1'b1;
        in_cmd    <= beat.cmd;
        in_expert <= beat.expert;
        in_column <= beat.column;
        in_sample <= beat.sample;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin : observe
    item_t  seen;
    stats_t want;
    in_taken = rst_n && in_valid && in_ready;
    if (in_taken) begin
      seen = {cmd_t'(in_cmd), in_expert, in_column, in_sample};
      resp_q.insert(resp_q.size(), collect_stats(seen));
    end
    if (rst_n && out_valid && out_ready) begin
      if (resp_q.size() == 0) begin
        report_mismatch("unexpected result beat", 64'(out_status), 64'(0));
      end else begin
        want = resp_q.pop_front();
        checked++;
        if (out_status !== want.status)
          report_mismatch("status", 64'(out_status), 64'(want.status));
        if (out_scaled_mean !== want.mean)
          report_mismatch("scaled_mean", 64'(out_scaled_mean), 64'(want.mean));
        if (out_sample_count !== want.count)
          report_mismatch("sample_count", 64'(out_sample_count), 64'(want.count));
      end
    end
  end

  initial begin : rx_backpressure
    wait (hold_go);
    @(posedge clk);
    rx_hold = 1'b1;
    repeat (300) @(posedge clk);
    rx_hold = 1'b0;
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic push_beat(cmd_t op, int unsigned e, int unsigned c, logic [15:0] s);
    item_t b;
    while (cmd_q.size() >= Q_DEPTH) @(posedge clk);
    b.cmd    = op;
    b.expert = e[EXP_W-1:0];
    b.column = c[COL_W-1:0];
    b.sample = s;
    cmd_q.insert(cmd_q.size(), b);
    issued++;
  endtask

  task automatic wait_idle();
    wait (checked == issued);
    @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t r, int unsigned v);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = r;
    cfg_wdata = v[CFG_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
    if (r == CFG_COLUMNS) cols_cfg = v[CFGCOL_W-1:0];
    else exps_cfg = v[CFGEXP_W-1:0];
    @(posedge clk);
  endtask

  task automatic set_shape(int unsigned cols, int unsigned exps);
    wait_idle();
    write_reg(CFG_COLUMNS, cols);
    write_reg(CFG_EXPERTS, exps);
  endtask

  // mostly hits a small hot set so reads find data
  task automatic random_beats(int unsigned n);
    int unsigned col_lim, exp_lim, pick, e, c, roll, i;
    int unsigned hot_e [8];
    int unsigned hot_c [8];
    logic [15:0] s;
    logic [31:0] r;
    cmd_t        op;
    col_lim = (cols_cfg > MAX_COLUMNS) ? MAX_COLUMNS : cols_cfg;
    exp_lim = (exps_cfg > MAX_EXPERTS) ? MAX_EXPERTS : exps_cfg;
    for (i = 0; i < 8; i++) begin
      hot_e[i] = (exp_lim == 0) ? $urandom_range(7) : $urandom_range(exp_lim - 1);
      hot_c[i] = (col_lim == 0) ? $urandom_range(1023) : $urandom_range(col_lim - 1);
    end
    repeat (n) begin
      roll = $urandom_range(99);
      if (roll < 55) op = CMD_ACC;
      else if (roll < 65) op = CMD_END;
      else if (roll < 95) op = CMD_READ;
      else op = CMD_NOP;
      roll = $urandom_range(99);
      if (roll < 70) begin
        pick = $urandom_range(7);
        e = hot_e[pick];
        c = hot_c[pick];
      end else if (roll < 85 && col_lim != 0 && exp_lim != 0) begin
        e = $urandom_range(exp_lim - 1);
        c = $urandom_range(col_lim - 1);
      end else begin
        e = $urandom_range(7);
        c = $urandom_range(1023);
      end
      r = $urandom;
      roll = $urandom_range(99);
      if (roll < 50) begin
        s = r[15:0];
      end else if (roll < 70) begin
        case (r[2:0])
          3'd0: s = 16'h8000;
          3'd1: s = 16'h7fff;
          3'd2: s = 16'hffff;
          3'd3: s = 16'h0001;
          default: s = 16'h0000;
        endcase
      end else begin
        s = {{8{r[8]}}, r[7:0]};
      end
      push_beat(op, e, c, s);
    end
  endtask

  initial begin : stimulus
    int unsigned k;
    for (k = 0; k < ENTRIES; k++) begin
      sum_store[k] = '0;
      cnt_store[k] = '0;
    end
    calls    = '0;
    stopped  = 1'b0;
    cols_cfg = CFGCOL_W'(MAX_COLUMNS);
    exps_cfg = CFGEXP_W'(1);

    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    wait (in_ready);
    @(posedge clk);

    tx_idle_pct = 19;
    rx_idle_pct = 46;

    // reset shape: 1024 columns, 1 expert
    push_beat(CMD_READ, 0, 0, 16'h0000);
    push_beat(CMD_ACC,  0, 0, 16'h8000);
    push_beat(CMD_ACC,  0, 0, 16'h7fff);
    push_beat(CMD_ACC,  0, 1023, 16'h0001);
    push_beat(CMD_ACC,  0, 5, 16'hffff);
    push_beat(CMD_ACC,  0, 6, 16'h0000);
    push_beat(CMD_ACC,  1, 0, 16'h0100);
    push_beat(CMD_READ, 0, 0, 16'h0000);
    push_beat(CMD_END,  0, 0, 16'h0000);
    push_beat(CMD_END,  7, 1023, 16'hffff);
    push_beat(CMD_READ, 0, 0, 16'h0000);
    push_beat(CMD_READ, 0, 1023, 16'h0000);
    push_beat(CMD_READ, 7, 1023, 16'h0000);
    push_beat(CMD_NOP,  7, 1023, 16'hffff);
    push_beat(CMD_READ, 0, 5, 16'h0000);

    set_shape(1, 1);
    push_beat(CMD_ACC,  0, 0, 16'h0080);
    push_beat(CMD_ACC,  0, 1, 16'h0080);
    push_beat(CMD_READ, 0, 0, 16'h0000);

    set_shape(MAX_COLUMNS, 0);
    push_beat(CMD_ACC,  0, 0, 16'h0100);
    push_beat(CMD_READ, 0, 0, 16'h0000);

    set_shape(0, MAX_EXPERTS);
    push_beat(CMD_ACC,  7, 0, 16'h0100);

    set_shape(2047, 15);
    push_beat(CMD_ACC,  7, 1023, 16'h8000);
    push_beat(CMD_READ, 7, 1023, 16'h0000);
    push_beat(CMD_READ, 0, 6, 16'h0000);
    push_beat(CMD_END,  3, 512, 16'h5a5a);

    set_shape(MAX_COLUMNS, MAX_EXPERTS);
    random_beats(40);
    hold_go = 1'b1;
    random_beats(110);
    set_shape($urandom_range(MAX_COLUMNS, 1), $urandom_range(MAX_EXPERTS, 1));
    random_beats(140);

    wait_idle();
    tx_idle_pct = 46;
    rx_idle_pct = 19;
    set_shape(1, MAX_EXPERTS);
    random_beats(60);
    set_shape($urandom_range(MAX_COLUMNS, 1), $urandom_range(MAX_EXPERTS, 1));
    random_beats(220);

    wait_idle();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_shape($urandom_range(64, 2), $urandom_range(4, 2));
    random_beats(120);
    set_shape(MAX_COLUMNS, MAX_EXPERTS);
    random_beats(100);

    set_shape(16, MAX_EXPERTS);
    push_beat(CMD_ACC,  0, 500, 16'h0100);
    push_beat(CMD_READ, 0, 500, 16'h0000);
    random_beats(40);

    wait_idle();
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
